FILE: design/bess_pkg.sv
`default_nettype none

package bess_pkg;

    localparam int NUM_LABELS  = 9;
    localparam int LABEL_W     = 4;
    localparam int TOTAL_W     = 32;
    localparam int QUEUE_DEPTH = 4;

    typedef logic [LABEL_W-1:0] label_t;
    typedef logic [TOTAL_W-1:0] total_t;

    localparam label_t TAG_O = 4'd0;

    // One classified token as it waits between front and back.
    typedef struct packed {
        label_t pred;
        label_t gold;
        logic   last;
        logic   clr;
    } token_word_t;

    function automatic logic is_b(input label_t t);
        return (t < LABEL_W'(NUM_LABELS)) && t[0];
    endfunction

    function automatic logic is_i(input label_t t);
        return (t < LABEL_W'(NUM_LABELS)) && (t != TAG_O) && !t[0];
    endfunction

endpackage

`default_nettype wire

FILE: design/bess_front.sv
`default_nettype none

module bess_front
    import bess_pkg::*;
#(
    parameter int SCORE_WIDTH = 16
)
(
    input  wire logic signed [SCORE_WIDTH-1:0] score_o,
    input  wire logic signed [SCORE_WIDTH-1:0] score_b_per,
    input  wire logic signed [SCORE_WIDTH-1:0] score_i_per,
    input  wire logic signed [SCORE_WIDTH-1:0] score_b_org,
    input  wire logic signed [SCORE_WIDTH-1:0] score_i_org,
    input  wire logic signed [SCORE_WIDTH-1:0] score_b_loc,
    input  wire logic signed [SCORE_WIDTH-1:0] score_i_loc,
    input  wire logic signed [SCORE_WIDTH-1:0] score_b_misc,
    input  wire logic signed [SCORE_WIDTH-1:0] score_i_misc,
    input  wire label_t                        gold_label,
    input  wire logic                          last_token,
    input  wire logic                          clear_totals,
    input  wire logic                          in_valid,
    input  wire logic                          queue_full,
    output logic                               push,
    output token_word_t                        word
);

    logic signed [SCORE_WIDTH-1:0] v1 [4];
    label_t                        i1 [4];
    logic signed [SCORE_WIDTH-1:0] v2 [2];
    label_t                        i2 [2];
    logic signed [SCORE_WIDTH-1:0] v3;
    label_t                        i3;
    label_t                        pred;

    // Left operand always carries the lower index, so only a strict win moves right:
    // that keeps the first maximum.
    always_comb
    begin
        v1[0] = (score_b_per  > score_o)     ? score_b_per  : score_o;
        i1[0] = (score_b_per  > score_o)     ? 4'd1 : 4'd0;
        v1[1] = (score_b_org  > score_i_per) ? score_b_org  : score_i_per;
        i1[1] = (score_b_org  > score_i_per) ? 4'd3 : 4'd2;
        v1[2] = (score_b_loc  > score_i_org) ? score_b_loc  : score_i_org;
        i1[2] = (score_b_loc  > score_i_org) ? 4'd5 : 4'd4;
        v1[3] = (score_b_misc > score_i_loc) ? score_b_misc : score_i_loc;
        i1[3] = (score_b_misc > score_i_loc) ? 4'd7 : 4'd6;
        for (int k = 0; k < 2; k++)
        begin
            v2[k] = (v1[2*k+1] > v1[2*k]) ? v1[2*k+1] : v1[2*k];
            i2[k] = (v1[2*k+1] > v1[2*k]) ? i1[2*k+1] : i1[2*k];
        end
        v3   = (v2[1] > v2[0]) ? v2[1] : v2[0];
        i3   = (v2[1] > v2[0]) ? i2[1] : i2[0];
        pred = (score_i_misc > v3) ? 4'd8 : i3;
    end

    assign push      = in_valid && !queue_full;
    assign word.pred = pred;
    assign word.gold = gold_label;
    assign word.last = last_token;
    assign word.clr  = clear_totals;

endmodule

`default_nettype wire

FILE: design/bess_queue.sv
`default_nettype none

module bess_queue
    import bess_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire token_word_t push_word,
    output logic             full,
    input  wire logic        pop,
    output logic             head_valid,
    output token_word_t      head_word
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    token_word_t        mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_word  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/bess_back.sv
`default_nettype none

module bess_back
    import bess_pkg::*;
#(
    parameter int MAX_ENTITIES = 32,
    parameter int MAX_TOKENS   = 128
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        head_valid,
    input  wire token_word_t head_word,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output total_t           true_pos,
    output total_t           false_pos,
    output total_t           false_neg
);

    localparam int POS_W = $clog2(MAX_TOKENS + 1);
    localparam int CNT_W = $clog2(MAX_ENTITIES + 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    label_t           prev_p_reg, prev_p_next;
    label_t           prev_g_reg, prev_g_next;
    logic             p_open_reg, p_open_next;
    logic [POS_W-1:0] p_start_reg, p_start_next;
    label_t           p_type_reg, p_type_next;
    logic             g_open_reg, g_open_next;
    logic [POS_W-1:0] g_start_reg, g_start_next;
    label_t           g_type_reg, g_type_next;
    logic [CNT_W-1:0] p_cnt_reg, p_cnt_next;
    logic [CNT_W-1:0] g_cnt_reg, g_cnt_next;
    logic [CNT_W-1:0] match_reg, match_next;
    total_t           tp_reg, tp_next;
    total_t           fp_reg, fp_next;
    total_t           fn_reg, fn_next;
    logic             out_valid_reg, out_valid_next;
    total_t           out_tp_reg, out_fp_reg, out_fn_reg;

    // token-stage (1) and sequence-end (2) views of the trackers
    logic             active;
    logic             p_brk, g_brk, pc1, gc1, pc2, gc2;
    logic             p_open1, g_open1;
    logic [POS_W-1:0] p_start1, g_start1;
    label_t           p_type1, g_type1;
    logic [CNT_W-1:0] p_cnt1, g_cnt1, match1;
    logic [CNT_W-1:0] p_cnt2, g_cnt2, match2;
    total_t           tp_base, fp_base, fn_base;
    logic             out_free;

    function automatic total_t sat_add(input total_t base, input logic [CNT_W-1:0] inc);
        logic [TOTAL_W:0] sum;
        sum = {1'b0, base} + (TOTAL_W+1)'(inc);
        return sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    endfunction

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = head_valid && (!head_word.last || out_free);
    assign active   = pos_reg < POS_W'(MAX_TOKENS);

    always_comb
    begin
        // token update; an open span breaks on anything but an I tag
        p_brk    = p_open_reg && !is_i(head_word.pred);
        g_brk    = g_open_reg && !is_i(head_word.gold);
        pc1      = p_brk && (p_cnt_reg < CNT_W'(MAX_ENTITIES));
        gc1      = g_brk && (g_cnt_reg < CNT_W'(MAX_ENTITIES));
        p_open1  = p_open_reg;
        p_start1 = p_start_reg;
        p_type1  = p_type_reg;
        g_open1  = g_open_reg;
        g_start1 = g_start_reg;
        g_type1  = g_type_reg;
        p_cnt1   = p_cnt_reg;
        g_cnt1   = g_cnt_reg;
        match1   = match_reg;
        if (active)
        begin
            p_cnt1  = p_cnt_reg + CNT_W'(pc1);
            g_cnt1  = g_cnt_reg + CNT_W'(gc1);
            match1  = match_reg + CNT_W'(pc1 && gc1 && (p_start_reg == g_start_reg)
                                         && (p_type_reg == g_type_reg));
            p_open1 = p_open_reg && !p_brk;
            g_open1 = g_open_reg && !g_brk;
            if (!p_open1 && (is_b(head_word.pred) || (is_i(head_word.pred)
                && (pos_reg == '0 || prev_p_reg == TAG_O))))
            begin
                p_open1  = 1'b1;
                p_start1 = pos_reg;
                p_type1  = head_word.pred;
            end
            if (!g_open1 && (is_b(head_word.gold) || (is_i(head_word.gold)
                && (pos_reg == '0 || prev_g_reg == TAG_O))))
            begin
                g_open1  = 1'b1;
                g_start1 = pos_reg;
                g_type1  = head_word.gold;
            end
        end

        // sequence end closes whatever is still open
        pc2    = p_open1 && (p_cnt1 < CNT_W'(MAX_ENTITIES));
        gc2    = g_open1 && (g_cnt1 < CNT_W'(MAX_ENTITIES));
        p_cnt2 = p_cnt1 + CNT_W'(pc2);
        g_cnt2 = g_cnt1 + CNT_W'(gc2);
        match2 = match1 + CNT_W'(pc2 && gc2 && (p_start1 == g_start1) && (p_type1 == g_type1));

        tp_base = head_word.clr ? '0 : tp_reg;
        fp_base = head_word.clr ? '0 : fp_reg;
        fn_base = head_word.clr ? '0 : fn_reg;

        pos_next       = pos_reg;
        prev_p_next    = prev_p_reg;
        prev_g_next    = prev_g_reg;
        p_open_next    = p_open_reg;
        p_start_next   = p_start_reg;
        p_type_next    = p_type_reg;
        g_open_next    = g_open_reg;
        g_start_next   = g_start_reg;
        g_type_next    = g_type_reg;
        p_cnt_next     = p_cnt_reg;
        g_cnt_next     = g_cnt_reg;
        match_next     = match_reg;
        tp_next        = tp_reg;
        fp_next        = fp_reg;
        fn_next        = fn_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (pop)
        begin
            tp_next = tp_base;
            fp_next = fp_base;
            fn_next = fn_base;
            if (head_word.last)
            begin
                tp_next        = sat_add(tp_base, match2);
                fp_next        = sat_add(fp_base, p_cnt2 - match2);
                fn_next        = sat_add(fn_base, g_cnt2 - match2);
                out_valid_next = 1'b1;
                pos_next       = '0;
                prev_p_next    = TAG_O;
                prev_g_next    = TAG_O;
                p_open_next    = 1'b0;
                p_start_next   = '0;
                p_type_next    = TAG_O;
                g_open_next    = 1'b0;
                g_start_next   = '0;
                g_type_next    = TAG_O;
                p_cnt_next     = '0;
                g_cnt_next     = '0;
                match_next     = '0;
            end
            else
            begin
                if (active)
                begin
                    pos_next    = pos_reg + 1'b1;
                    prev_p_next = head_word.pred;
                    prev_g_next = head_word.gold;
                end
                p_open_next  = p_open1;
                p_start_next = p_start1;
                p_type_next  = p_type1;
                g_open_next  = g_open1;
                g_start_next = g_start1;
                g_type_next  = g_type1;
                p_cnt_next   = p_cnt1;
                g_cnt_next   = g_cnt1;
                match_next   = match1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            prev_p_reg    <= TAG_O;
            prev_g_reg    <= TAG_O;
            p_open_reg    <= 1'b0;
            p_start_reg   <= '0;
            p_type_reg    <= TAG_O;
            g_open_reg    <= 1'b0;
            g_start_reg   <= '0;
            g_type_reg    <= TAG_O;
            p_cnt_reg     <= '0;
            g_cnt_reg     <= '0;
            match_reg     <= '0;
            tp_reg        <= '0;
            fp_reg        <= '0;
            fn_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            prev_p_reg    <= prev_p_next;
            prev_g_reg    <= prev_g_next;
            p_open_reg    <= p_open_next;
            p_start_reg   <= p_start_next;
            p_type_reg    <= p_type_next;
            g_open_reg    <= g_open_next;
            g_start_reg   <= g_start_next;
            g_type_reg    <= g_type_next;
            p_cnt_reg     <= p_cnt_next;
            g_cnt_reg     <= g_cnt_next;
            match_reg     <= match_next;
            tp_reg        <= tp_next;
            fp_reg        <= fp_next;
            fn_reg        <= fn_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_word.last)
        begin
            out_tp_reg <= tp_next;
            out_fp_reg <= fp_next;
            out_fn_reg <= fn_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign true_pos  = out_tp_reg;
    assign false_pos = out_fp_reg;
    assign false_neg = out_fn_reg;

    // matches never outnumber the spans of either kind
    assert property (@(posedge clk) disable iff (!rst_n)
        (match_reg <= p_cnt_reg) && (match_reg <= g_cnt_reg))
        else $error("match count exceeds span count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (p_cnt_reg <= CNT_W'(MAX_ENTITIES)) && (g_cnt_reg <= CNT_W'(MAX_ENTITIES)))
        else $error("span count beyond entity limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop && head_word.last |=> out_valid_reg && (pos_reg == '0) && !p_open_reg && !g_open_reg)
        else $error("sequence end did not post totals and clear trackers");

    assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && head_word.last && out_valid_reg && out_stall |-> !pop)
        else $error("last word popped over an untaken result");

endmodule

`default_nettype wire

FILE: design/bio_entity_span_scoring.sv
`default_nettype none

// BIO entity span scorer. Takes one token word per cycle while in_stall is low (nine
// class scores and a gold tag), picks the first highest score as the predicted tag,
// chunks predicted and gold tags into entity spans and, on the word marked last_token,
// returns saturating running totals of true positives, false positives and false
// negatives. Throughput is one word per clock while in_stall is low: the argmax tree
// sits in the front, the span trackers and total adders sit in the back, and a
// four-word queue sits between them. A result is registered in the back after its
// last word has passed through the queue; while a result waits on out_stall the back
// keeps consuming words that are not marked last, and in_stall rises only when the
// queue is full.
module bio_entity_span_scoring
    import bess_pkg::*;
#(
    parameter int MAX_ENTITIES = 32,
    parameter int MAX_TOKENS   = 128,
    parameter int SCORE_WIDTH  = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [SCORE_WIDTH-1:0] score_o,
    input  wire logic signed [SCORE_WIDTH-1:0] score_b_per,
    input  wire logic signed [SCORE_WIDTH-1:0] score_i_per,
    input  wire logic signed [SCORE_WIDTH-1:0] score_b_org,
    input  wire logic signed [SCORE_WIDTH-1:0] score_i_org,
    input  wire logic signed [SCORE_WIDTH-1:0] score_b_loc,
    input  wire logic signed [SCORE_WIDTH-1:0] score_i_loc,
    input  wire logic signed [SCORE_WIDTH-1:0] score_b_misc,
    input  wire logic signed [SCORE_WIDTH-1:0] score_i_misc,
    input  wire label_t                        gold_label,
    input  wire logic                          last_token,
    input  wire logic                          clear_totals,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output total_t                             true_pos,
    output total_t                             false_pos,
    output total_t                             false_neg
);

    logic        push;
    logic        pop;
    logic        head_valid;
    token_word_t push_word;
    token_word_t head_word;

    bess_front #(
        .SCORE_WIDTH (SCORE_WIDTH)
    ) u_front (
        .score_o      (score_o),
        .score_b_per  (score_b_per),
        .score_i_per  (score_i_per),
        .score_b_org  (score_b_org),
        .score_i_org  (score_i_org),
        .score_b_loc  (score_b_loc),
        .score_i_loc  (score_i_loc),
        .score_b_misc (score_b_misc),
        .score_i_misc (score_i_misc),
        .gold_label   (gold_label),
        .last_token   (last_token),
        .clear_totals (clear_totals),
        .in_valid     (in_valid),
        .queue_full   (in_stall),
        .push         (push),
        .word         (push_word)
    );

    bess_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_word  (push_word),
        .full       (in_stall),
        .pop        (pop),
        .head_valid (head_valid),
        .head_word  (head_word)
    );

    bess_back #(
        .MAX_ENTITIES (MAX_ENTITIES),
        .MAX_TOKENS   (MAX_TOKENS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_word  (head_word),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .true_pos   (true_pos),
        .false_pos  (false_pos),
        .false_neg  (false_neg)
    );

endmodule

`default_nettype wire
